// ===== rtl/sorted_min_priority_queue_core_assert.svh =====
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Checked on every rising clk_i edge, muted while rst_ni is low.
`define SMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define SMPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/smpq_pkg.sv =====
// Types and codes for the sorted minimum priority queue.
package smpq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned FieldW = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned CapW   = 4;
  localparam logic [CapW-1:0] CapReset = 4'd8;

  typedef struct packed {
    op_e                operation;
    logic [FieldW-1:0]  value_in;
  } cmd_t;

  typedef struct packed {
    logic [FieldW-1:0]  value_out;
    status_e            status;
    logic [CountW-1:0]  count;
  } res_t;

  // Per-cycle commands broadcast along the cell row.
  typedef struct packed {
    logic ins;   // insert shifts up from the insertion point
    logic rem;   // remove shifts everything down one place
  } cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
// One entry of the sorted row: compare with the key and shift left or right.
module smpq_cell #(
  parameter int unsigned VW = 32
) (
  input  logic                 clk_i,
  input  smpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 occ_i,        // entry below the element count
  input  logic signed [VW-1:0] key_i,
  input  logic                 left_gt_i,    // lower neighbour is above the key
  input  logic signed [VW-1:0] left_val_i,
  input  logic signed [VW-1:0] right_val_i,
  output logic                 gt_o,
  output logic signed [VW-1:0] val_o
);

  logic signed [VW-1:0] val_q, val_d;

  assign gt_o  = occ_i && (val_q > key_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || !occ_i) begin
        val_d = key_i;
      end
    end else if (ctrl_i.rem) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== rtl/sorted_min_priority_queue_core.sv =====
// Top level of the sorted minimum priority queue: cell row, count and APB register.
//
//  channel   direction  transfer taken when                     payload
//  command   in         start && !busy at rising clk_i          cmd_i (operation, value_in)
//  result    out        every cycle with done_o high            res_o (value_out, status, count)
//  config    in         psel && penable && pwrite && !paddr[2]  pwdata[3:0] -> capacity
//
// One command every cycle: all cells compare against the key in parallel and
// shift in the same edge, so the cell row sets the pace and busy stays low.
// The result is registered and appears in the cycle after the command transfer, for one cycle only.
// Reset clears the element count, capacity returns to eight; cell contents
// are left as they are, since entries at or above the count are never read.
// The receiver cannot stall, so no result is ever held back.
module sorted_min_priority_queue_core #(
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  smpq_pkg::cmd_t                 cmd_i,
  // result channel
  output logic                           done_o,
  output smpq_pkg::res_t                 res_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  `include "sorted_min_priority_queue_core_assert.svh"

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > smpq_pkg::CapW) ? CW : smpq_pkg::CapW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration register (byte address 0)
  // ---------------------------------------------------------------------------
  logic [smpq_pkg::CapW-1:0] cap_q;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= smpq_pkg::CapReset;
    end else if (cfg_wr) begin
      cap_q <= pwdata[smpq_pkg::CapW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode
  // ---------------------------------------------------------------------------
  logic                          take;
  logic [CW-1:0]                 count_q, count_d;
  logic [CmpW-1:0]               cap_ext, count_ext, usable;
  logic                          full, empty;
  logic signed [VALUE_WIDTH-1:0] key;
  smpq_pkg::cell_ctrl_t          ctrl;
  smpq_pkg::status_e             status_d;
  logic [smpq_pkg::FieldW-1:0]   value_d;

  assign busy      = 1'b0;
  assign take      = start && !busy;
  assign cap_ext   = CmpW'(cap_q);
  assign count_ext = CmpW'(count_q);
  assign usable    = (cap_ext > DepthC) ? DepthC : cap_ext;
  assign full      = count_ext >= usable;
  assign empty     = (count_q == '0);
  assign key       = VALUE_WIDTH'($signed(cmd_i.value_in));

  // ---------------------------------------------------------------------------
  // Cell row: entry i holds the i-th smallest value
  // ---------------------------------------------------------------------------
  logic [DEPTH-1:0]              occ, gt;
  logic signed [VALUE_WIDTH-1:0] vals [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = CW'(i) < count_q;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    smpq_cell #(
      .VW (VALUE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[g]),
      .key_i       (key),
      .left_gt_i   ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g - 1]),
      .left_val_i  (vals[(g == 0) ? 0 : g - 1]),
      .right_val_i (vals[(g == DEPTH - 1) ? g : g + 1]),
      .gt_o        (gt[g]),
      .val_o       (vals[g])
    );
  end

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = smpq_pkg::ST_OK;
    value_d  = '0;
    unique case (cmd_i.operation)
      smpq_pkg::OP_INSERT: begin
        if (full) begin
          status_d = smpq_pkg::ST_FULL;
        end else begin
          ctrl.ins = take;
          count_d  = count_q + 1'b1;
        end
      end
      smpq_pkg::OP_REMOVE: begin
        if (empty) begin
          status_d = smpq_pkg::ST_EMPTY;
        end else begin
          ctrl.rem = take;
          count_d  = count_q - 1'b1;
          value_d  = smpq_pkg::FieldW'(vals[0]);
        end
      end
      smpq_pkg::OP_CLEAR: count_d = '0;
      default: ;   // no operation
    endcase
  end

  // ---------------------------------------------------------------------------
  // Count and result registers
  // ---------------------------------------------------------------------------
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= take;
      if (take) begin
        count_q <= count_d;
      end
    end
  end

  smpq_pkg::res_t res_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q.value_out <= value_d;
      res_q.status    <= status_d;
      res_q.count     <= smpq_pkg::CountW'(count_d);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SMPQ_ASSERT(a_one_result, take |=> done_o, "command transfer without a result")
  `SMPQ_ASSERT(a_no_spurious, !take |=> !done_o, "result without a command transfer")
  `SMPQ_ASSERT(a_full_keeps, done_o && res_o.status == smpq_pkg::ST_FULL |-> $stable(count_q), "full insert changed the count")
  `SMPQ_ASSERT(a_empty_zero, done_o && res_o.status == smpq_pkg::ST_EMPTY |-> res_o.value_out == '0 && count_q == '0, "empty remove returned data")
  `SMPQ_ASSERT_ALWAYS(a_count_range, count_q <= CW'(DEPTH), "element count beyond depth")

endmodule
